// File: rtl/core/ccr_pkg.sv
// Shared types and constants of the closed Catmull-Rom spline evaluator.
`default_nettype none

package ccr_pkg;

  localparam int COORD_W  = 32;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 6;
  localparam int FRACIN_W = 16;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [1:0] COORD_X = 2'd0;
  localparam logic [1:0] COORD_Y = 2'd1;
  localparam logic [1:0] COORD_Z = 2'd2;

  typedef struct packed {
    logic                       op;
    logic [IDX_W-1:0]           point_index;
    logic signed [COORD_W-1:0]  in_x;
    logic signed [COORD_W-1:0]  in_y;
    logic signed [COORD_W-1:0]  in_z;
    logic [IDX_W-1:0]           segment;
    logic [FRACIN_W-1:0]        fraction;
  } ccr_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
    logic                       bad_segment;
  } ccr_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } ccr_point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CUBE,
    ST_WGT,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } ccr_state_t;

endpackage

`default_nettype wire

// File: rtl/core/ccr_point_mem.sv
// Control point table with one write port and one registered read port.
`default_nettype none

module ccr_point_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  ccr_pkg::ccr_point_t wdata,
  input  logic [AW-1:0]       raddr,
  output ccr_pkg::ccr_point_t rdata
);

  ccr_pkg::ccr_point_t mem [DEPTH];
  ccr_pkg::ccr_point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/closed_catmull_rom_evaluator.sv
// Top level of the closed uniform Catmull-Rom spline evaluator.
//
// A request is taken at a rising edge where start is high and busy is low.
// A write request (op low) stores one Q16.16 point at point_index in the
// same edge and returns nothing; busy stays low, so requests may follow
// every cycle. An evaluate request picks four points around segment with
// wrap-around and returns one result on out_res, marked by out_valid for
// exactly one cycle. A good segment goes through t squared, t cubed and the
// basis weights, then twelve products through the single shared multiplier
// fed from the point table's read port, and a drain of the multiply,
// accumulate and round stages before the result cycle. busy is high in
// between and drops in the result cycle, when a new request can be taken.
// A segment not below the point count returns bad_segment with zero
// coordinates in the cycle after acceptance. The receiver cannot stall;
// results are not held. Reset clears the sequencer and sets the point count
// to four; the table is not cleared. cfg_we writes the point count; it must
// be written only while idle, which the block itself does not enforce.
`default_nettype none

module closed_catmull_rom_evaluator #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ccr_pkg::ccr_in_t                in_req,
  output logic                            out_valid,
  output ccr_pkg::ccr_out_t               out_res,
  input  logic                            cfg_we,
  input  logic [ccr_pkg::CNT_W-1:0]       cfg_wdata
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int FW = FRAC_BITS;
  localparam int CW = ccr_pkg::CNT_W;
  localparam int IW = ccr_pkg::IDX_W;
  localparam int DW = ccr_pkg::COORD_W;
  localparam int QW = FW + 3;
  localparam int EW = FW + 4;
  localparam int PW = DW + QW;
  localparam int SW = PW + 2;
  localparam int RW = SW - FW;
  localparam int FRACIN_PAD = ccr_pkg::FRACIN_W;

  ccr_pkg::ccr_state_t state_r, state_nxt;

  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          idx_r [4];
  logic [FW-1:0]          f_r;
  logic [FW-1:0]          tt_r;
  logic signed [QW-1:0]   q_r [4];
  logic                   bad_r;
  logic [1:0]             coord_r;
  logic [1:0]             pk_r;
  logic                   s1_v_r, s2_v_r, s3_v_r;
  logic [1:0]             s1_c_r, s2_c_r, s3_c_r;
  logic [1:0]             s1_k_r, s2_k_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [SW-1:0]   acc_r;
  logic signed [DW-1:0]   res_x_r, res_y_r, res_z_r;

  logic                   take;
  logic                   take_eval;
  logic [CW-1:0]          n_eff;
  logic [CW-1:0]          seg7;
  logic                   seg_bad;
  logic [CW-1:0]          i2, i3, i0;
  logic [FW+FRACIN_PAD-1:0] frac_ext;
  logic [FW-1:0]          f_in;
  logic [FW-1:0]          tt_now;
  logic signed [EW-1:0]   tte, ttte, fe, two_s;
  logic signed [EW-1:0]   q1, q2, q3, q4;
  logic signed [DW-1:0]   mul_a;
  logic signed [QW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [DW-1:0]   coord_sel;
  logic signed [SW:0]     rnd;
  logic signed [RW-1:0]   rsh;
  logic signed [DW-1:0]   sat;
  logic                   wr_en;
  logic [AW+IW-1:0]       waddr_ext;
  logic [AW+CW-1:0]       raddr_ext;
  ccr_pkg::ccr_point_t    wr_pt;
  ccr_pkg::ccr_point_t    rd_pt;

  assign take      = start && !busy;
  assign take_eval = take && (in_req.op == ccr_pkg::OP_EVAL);

  assign n_eff   = (32'(cnt_r) > MAX_POINTS) ? CW'(MAX_POINTS) : cnt_r;
  assign seg7    = {1'b0, in_req.segment};
  assign seg_bad = (seg7 >= n_eff);
  assign i2      = ((seg7 + 7'd1) == n_eff) ? '0 : seg7 + 7'd1;
  assign i3      = ((i2 + 7'd1) == n_eff) ? '0 : i2 + 7'd1;
  assign i0      = (seg7 != '0) ? seg7 - 7'd1 : n_eff - 7'd1;

  assign frac_ext = {{FW{1'b0}}, in_req.fraction};
  assign f_in     = frac_ext[FW-1:0];

  assign wr_en     = take && (in_req.op == ccr_pkg::OP_WRITE)
                     && (32'(in_req.point_index) < MAX_POINTS);
  assign waddr_ext = {{AW{1'b0}}, in_req.point_index};
  assign raddr_ext = {{AW{1'b0}}, idx_r[pk_r]};
  assign wr_pt.x   = in_req.in_x;
  assign wr_pt.y   = in_req.in_y;
  assign wr_pt.z   = in_req.in_z;

  ccr_point_mem #(
    .DEPTH (MAX_POINTS)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (wr_pt),
    .raddr (raddr_ext[AW-1:0]),
    .rdata (rd_pt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= ccr_pkg::CNT_RESET;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ccr_pkg::ST_IDLE, ccr_pkg::ST_OUT: begin
        if (take_eval) begin
          state_nxt = seg_bad ? ccr_pkg::ST_OUT : ccr_pkg::ST_SQ;
        end else begin
          state_nxt = ccr_pkg::ST_IDLE;
        end
      end
      ccr_pkg::ST_SQ:   state_nxt = ccr_pkg::ST_CUBE;
      ccr_pkg::ST_CUBE: state_nxt = ccr_pkg::ST_WGT;
      ccr_pkg::ST_WGT:  state_nxt = ccr_pkg::ST_MAC;
      ccr_pkg::ST_MAC: begin
        if (coord_r == ccr_pkg::COORD_Z && pk_r == 2'd3) begin
          state_nxt = ccr_pkg::ST_DRAIN;
        end
      end
      ccr_pkg::ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = ccr_pkg::ST_OUT;
        end
      end
      default: state_nxt = ccr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ccr_pkg::ST_IDLE: busy = 1'b0;
      ccr_pkg::ST_OUT: begin
        busy      = 1'b0;
        out_valid = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take_eval) begin
      idx_r[0] <= i0;
      idx_r[1] <= seg7;
      idx_r[2] <= i2;
      idx_r[3] <= i3;
      f_r      <= f_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r <= 1'b0;
    end else if (take_eval) begin
      bad_r <= seg_bad;
    end
  end

  assign tt_now = prod_r[2*FW-1:FW];

  always_comb begin
    unique case (s1_c_r)
      ccr_pkg::COORD_X: coord_sel = rd_pt.x;
      ccr_pkg::COORD_Y: coord_sel = rd_pt.y;
      default:          coord_sel = rd_pt.z;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ccr_pkg::ST_SQ: begin
        mul_a = signed'({{(DW-FW){1'b0}}, f_r});
        mul_b = signed'({3'b000, f_r});
      end
      ccr_pkg::ST_CUBE: begin
        mul_a = signed'({{(DW-FW){1'b0}}, tt_now});
        mul_b = signed'({3'b000, f_r});
      end
      default: begin
        mul_a = coord_sel;
        mul_b = q_r[s1_k_r];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  assign tte   = signed'({4'b0000, tt_r});
  assign ttte  = signed'({4'b0000, tt_now});
  assign fe    = signed'({4'b0000, f_r});
  assign two_s = signed'({3'b001, {(FW+1){1'b0}}});
  assign q1    = (tte <<< 1) - ttte - fe;
  assign q2    = (ttte <<< 1) + ttte - (tte <<< 2) - tte + two_s;
  assign q3    = (tte <<< 2) + fe - (ttte <<< 1) - ttte;
  assign q4    = ttte - tte;

  always_ff @(posedge clk) begin
    if (state_r == ccr_pkg::ST_CUBE) begin
      tt_r <= tt_now;
    end
    if (state_r == ccr_pkg::ST_WGT) begin
      q_r[0] <= q1[QW-1:0];
      q_r[1] <= q2[QW-1:0];
      q_r[2] <= q3[QW-1:0];
      q_r[3] <= q4[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= ccr_pkg::COORD_X;
      pk_r    <= 2'd0;
    end else if (state_r == ccr_pkg::ST_WGT) begin
      coord_r <= ccr_pkg::COORD_X;
      pk_r    <= 2'd0;
    end else if (state_r == ccr_pkg::ST_MAC) begin
      pk_r <= pk_r + 2'd1;
      if (pk_r == 2'd3) begin
        coord_r <= coord_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= (state_r == ccr_pkg::ST_MAC);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && (s2_k_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    s1_c_r <= coord_r;
    s1_k_r <= pk_r;
    s2_c_r <= s1_c_r;
    s2_k_r <= s1_k_r;
    s3_c_r <= s2_c_r;
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      if (s2_k_r == 2'd0) begin
        acc_r <= SW'(prod_r);
      end else begin
        acc_r <= acc_r + SW'(prod_r);
      end
    end
  end

  assign rnd = (SW+1)'(acc_r) + ((SW+1)'(1) <<< FW);
  assign rsh = rnd[SW:FW+1];

  always_comb begin
    if (rsh[RW-1:DW-1] == '0 || rsh[RW-1:DW-1] == '1) begin
      sat = rsh[DW-1:0];
    end else if (rsh[RW-1]) begin
      sat = signed'({1'b1, {(DW-1){1'b0}}});
    end else begin
      sat = signed'({1'b0, {(DW-1){1'b1}}});
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      unique case (s3_c_r)
        ccr_pkg::COORD_X: res_x_r <= sat;
        ccr_pkg::COORD_Y: res_y_r <= sat;
        default:          res_z_r <= sat;
      endcase
    end
  end

  assign out_res.out_x       = bad_r ? '0 : res_x_r;
  assign out_res.out_y       = bad_r ? '0 : res_y_r;
  assign out_res.out_z       = bad_r ? '0 : res_z_r;
  assign out_res.bad_segment = bad_r;

endmodule

`default_nettype wire

// File: rtl/core/ccr_checker.sv
// Port-level checker for the spline evaluator and its bind statement.
`default_nettype none

module ccr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input ccr_pkg::ccr_in_t          in_req,
  input logic                      out_valid,
  input ccr_pkg::ccr_out_t         out_res
);

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (busy || out_valid))
    else $error("Busy period ended without a result.");

  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result strobe while busy.");

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.op == ccr_pkg::OP_WRITE) |=> (!busy && !out_valid))
    else $error("Write request made the block busy or gave a result.");

  a_eval_result_or_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.op == ccr_pkg::OP_EVAL) |=> (busy || out_valid))
    else $error("Evaluate request was dropped.");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.bad_segment) |->
      (out_res.out_x == 0 && out_res.out_y == 0 && out_res.out_z == 0))
    else $error("Bad segment result carries nonzero coordinates.");

endmodule

bind closed_catmull_rom_evaluator ccr_checker u_ccr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);

`default_nettype wire
